// ===== hw/rtl/nmea_rmc_field_extractor_core_defines.svh =====
// assertion macros used by the nmea rmc extractor checker
`ifndef NMEA_RMC_FIELD_EXTRACTOR_CORE_DEFINES_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_CORE_DEFINES_SVH

// concurrent assertion sampled on the rising edge, off while in reset
`define NRMC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition in one cycle implies a condition in the next
`define NRMC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  `NRMC_ASSERT(label, clk, rst_n, (pre) |=> (post), msg)

`endif

// ===== hw/rtl/nrmc_pkg.sv =====
// shared types, constants and recipe tables of the nmea rmc extractor
package nrmc_pkg;

  // characters of interest
  localparam logic [7:0] TagChar   = 8'h43;  // 'C'
  localparam logic [7:0] OkChar    = 8'h41;  // 'A'
  localparam logic [7:0] CommaChar = 8'h2C;  // ','

  // result status codes
  localparam logic [1:0] StByte    = 2'd0;
  localparam logic [1:0] StDone    = 2'd1;
  localparam logic [1:0] StTimeout = 2'd2;

  // recipe codes
  localparam logic [1:0] ModeStatusTimeDate = 2'd0;
  localparam logic [1:0] ModeLat            = 2'd1;
  localparam logic [1:0] ModeLon            = 2'd2;
  localparam logic [1:0] ModeTimeDate       = 2'd3;

  // register map
  localparam int unsigned AddrW    = 3;
  localparam logic        RegMode  = 1'b0;
  localparam logic        RegLimit = 1'b1;
  localparam logic [1:0]  ModeReset  = ModeStatusTimeDate;
  localparam logic [15:0] LimitReset = 16'd4200;

  // field geometry
  localparam logic [3:0] TimeLast = 4'd5;
  localparam logic [3:0] MaxPos   = 4'd11;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // classified input beat
  typedef struct packed {
    logic [7:0] data;
    logic       is_tag;
    logic       is_ok;
    logic       is_comma;
  } item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] limit;
  } cfg_t;

  // commas to count before the tail field
  function automatic logic [3:0] comma_target(input logic [1:0] mode);
    logic [3:0] r;
    case (mode)
      ModeStatusTimeDate: r = 4'd7;
      ModeLat:            r = 4'd3;
      ModeLon:            r = 4'd5;
      default:            r = 4'd8;
    endcase
    return r;
  endfunction

  // characters in the tail field
  function automatic logic [3:0] tail_len(input logic [1:0] mode);
    logic [3:0] r;
    case (mode)
      ModeLat: r = 4'd11;
      ModeLon: r = 4'd12;
      default: r = 4'd6;
    endcase
    return r;
  endfunction

  // buffer position of the first tail character
  function automatic logic [3:0] tail_base(input logic [1:0] mode);
    logic [3:0] r;
    case (mode)
      ModeLat, ModeLon: r = 4'd0;
      default:          r = 4'd6;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/nmea_rmc_field_extractor_core.sv =====
// top level of the nmea rmc field extractor
// an accepted byte is queued, and any result it yields is then registered on out_valid_o
// throughput: one byte per cycle, set by the single-step recipe state machine, unless stalled
// a two-entry queue parts input acceptance from the result register, so either side may stall
// reset: asynchronous, active low; clears state, queue and result slot, loads register defaults
// no clearing pass after reset: bytes are taken from the first cycle
module nmea_rmc_field_extractor_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 captured_byte_o,
  output logic [3:0]                 buffer_position_o,
  output logic [1:0]                 result_status_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nrmc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  nrmc_pkg::cfg_t  cfg;
  nrmc_pkg::item_t front_item;
  nrmc_pkg::item_t back_item;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  // configuration registers
  nrmc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // byte intake and classification
  nrmc_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (front_item)
  );

  // decoupling queue
  nrmc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (back_item)
  );

  // recipe engine and result register
  nrmc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .empty_i           (q_empty),
    .item_i            (back_item),
    .pop_o             (pop),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .captured_byte_o   (captured_byte_o),
    .buffer_position_o (buffer_position_o),
    .result_status_o   (result_status_o)
  );

endmodule

// ===== hw/rtl/nrmc_cfg.sv =====
// apb register block holding recipe select and search limit
module nrmc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nrmc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output nrmc_pkg::cfg_t             cfg_o
);

  logic [1:0]  mode_q, mode_d;
  logic [15:0] limit_q, limit_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register write decode
  always_comb begin
    mode_d  = mode_q;
    limit_d = limit_q;
    if (wr_en) begin
      case (paddr[2])
        nrmc_pkg::RegMode:  mode_d  = pwdata[1:0];
        nrmc_pkg::RegLimit: limit_d = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= nrmc_pkg::ModeReset;
      limit_q <= nrmc_pkg::LimitReset;
    end else begin
      mode_q  <= mode_d;
      limit_q <= limit_d;
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      nrmc_pkg::RegMode:  prdata = {30'd0, mode_q};
      nrmc_pkg::RegLimit: prdata = {16'd0, limit_q};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg_o.mode  = mode_q;
  assign cfg_o.limit = limit_q;

endmodule

// ===== hw/rtl/nrmc_front.sv =====
// input side: accepts stream bytes and tags them with their character class
module nrmc_front (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      rx_byte_i,
  input  logic            q_full_i,
  output logic            push_o,
  output nrmc_pkg::item_t item_o
);

  // take a beat whenever the queue has room
  assign in_ready_o = ~q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  // character classification
  assign item_o.data     = rx_byte_i;
  assign item_o.is_tag   = (rx_byte_i == nrmc_pkg::TagChar);
  assign item_o.is_ok    = (rx_byte_i == nrmc_pkg::OkChar);
  assign item_o.is_comma = (rx_byte_i == nrmc_pkg::CommaChar);

endmodule

// ===== hw/rtl/nrmc_fifo.sv =====
// short register queue between front and back
module nrmc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nrmc_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output nrmc_pkg::item_t item_o
);

  localparam logic [nrmc_pkg::QueuePtrW-1:0] PtrLast =
    nrmc_pkg::QueuePtrW'(nrmc_pkg::QueueDepth - 1);
  localparam logic [nrmc_pkg::QueueCntW-1:0] CntFull =
    nrmc_pkg::QueueCntW'(nrmc_pkg::QueueDepth);

  nrmc_pkg::item_t                    slot_q [nrmc_pkg::QueueDepth];
  logic [nrmc_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [nrmc_pkg::QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [nrmc_pkg::QueueCntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/nrmc_back.sv =====
// back end: recipe state machine and result register
module nrmc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nrmc_pkg::cfg_t  cfg_i,
  input  logic            empty_i,
  input  nrmc_pkg::item_t item_i,
  output logic            pop_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      captured_byte_o,
  output logic [3:0]      buffer_position_o,
  output logic [1:0]      result_status_o
);

  typedef enum logic [2:0] {
    PhHunt   = 3'd0,
    PhSkip1  = 3'd1,
    PhTime   = 3'd2,
    PhSkipC  = 3'd3,
    PhStatus = 3'd4,
    PhCommas = 3'd5,
    PhTail   = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] hunt_q, hunt_d;
  logic [3:0]  comma_q, comma_d;
  logic [3:0]  cidx_q, cidx_d;
  logic [1:0]  jmode_q, jmode_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic [3:0]  pos_q, pos_d;
  logic [1:0]  status_q, status_d;

  // pop a beat when the result slot is free or draining
  assign pop_o = ~empty_i & (~out_valid_q | out_ready_i);

  // recipe step for the popped beat
  always_comb begin
    logic        emit;
    logic [7:0]  e_byte;
    logic [3:0]  e_pos;
    logic [1:0]  e_st;
    logic [15:0] h1;
    logic [3:0]  c1;
    logic [4:0]  t1;

    phase_d = phase_q;
    hunt_d  = hunt_q;
    comma_d = comma_q;
    cidx_d  = cidx_q;
    jmode_d = jmode_q;
    emit    = 1'b0;
    e_byte  = item_i.data;
    e_pos   = cidx_q;
    e_st    = nrmc_pkg::StByte;
    h1      = hunt_q + 16'd1;
    c1      = comma_q + 4'd1;
    t1      = {1'b0, cidx_q} + 5'd1;

    if (pop_o) begin
      case (phase_q)
        PhSkip1: begin
          phase_d = PhTime;
          cidx_d  = '0;
        end
        PhTime: begin
          emit = 1'b1;
          if (cidx_q == nrmc_pkg::TimeLast) begin
            cidx_d  = '0;
            comma_d = '0;
            phase_d = (jmode_q == nrmc_pkg::ModeStatusTimeDate) ? PhSkipC : PhCommas;
          end else begin
            cidx_d = t1[3:0];
          end
        end
        PhSkipC: begin
          phase_d = PhStatus;
        end
        PhStatus: begin
          comma_d = '0;
          if (item_i.is_ok) begin
            phase_d = PhCommas;
          end else begin
            phase_d = PhHunt;
            cidx_d  = '0;
          end
        end
        PhCommas: begin
          if (item_i.is_comma) begin
            if (c1 >= nrmc_pkg::comma_target(jmode_q)) begin
              comma_d = '0;
              cidx_d  = '0;
              phase_d = PhTail;
            end else begin
              comma_d = c1;
            end
          end
        end
        PhTail: begin
          emit  = 1'b1;
          e_pos = nrmc_pkg::tail_base(jmode_q) + cidx_q;
          if (t1 >= {1'b0, nrmc_pkg::tail_len(jmode_q)}) begin
            e_st    = nrmc_pkg::StDone;
            phase_d = PhHunt;
            hunt_d  = '0;
            comma_d = '0;
            cidx_d  = '0;
          end else begin
            cidx_d = t1[3:0];
          end
        end
        default: begin
          // hunting, also any unused phase code
          phase_d = PhHunt;
          if (item_i.is_tag) begin
            jmode_d = cfg_i.mode;
            comma_d = '0;
            cidx_d  = '0;
            phase_d = (cfg_i.mode == nrmc_pkg::ModeLat ||
                       cfg_i.mode == nrmc_pkg::ModeLon) ? PhCommas : PhSkip1;
          end else if (h1 >= cfg_i.limit || h1 == '0) begin
            emit    = 1'b1;
            e_byte  = '0;
            e_pos   = '0;
            e_st    = nrmc_pkg::StTimeout;
            hunt_d  = '0;
            comma_d = '0;
            cidx_d  = '0;
          end else begin
            hunt_d = h1;
          end
        end
      endcase
    end

    // result slot
    out_valid_d = out_valid_q & ~out_ready_i;
    byte_d      = byte_q;
    pos_d       = pos_q;
    status_d    = status_q;
    if (emit) begin
      out_valid_d = 1'b1;
      byte_d      = e_byte;
      pos_d       = e_pos;
      status_d    = e_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      hunt_q      <= '0;
      comma_q     <= '0;
      cidx_q      <= '0;
      jmode_q     <= nrmc_pkg::ModeStatusTimeDate;
      out_valid_q <= 1'b0;
      byte_q      <= '0;
      pos_q       <= '0;
      status_q    <= nrmc_pkg::StByte;
    end else begin
      phase_q     <= phase_d;
      hunt_q      <= hunt_d;
      comma_q     <= comma_d;
      cidx_q      <= cidx_d;
      jmode_q     <= jmode_d;
      out_valid_q <= out_valid_d;
      byte_q      <= byte_d;
      pos_q       <= pos_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign captured_byte_o   = byte_q;
  assign buffer_position_o = pos_q;
  assign result_status_o   = status_q;

endmodule

// ===== hw/rtl/nrmc_chk.sv =====
// port-level checker for the extractor, bound to the top level
`include "nmea_rmc_field_extractor_core_defines.svh"

module nrmc_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] captured_byte_o,
  input logic [3:0] buffer_position_o,
  input logic [1:0] result_status_o
);

  // a stalled result beat stays offered
  `NRMC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped while stalled")

  // a stalled result beat keeps its payload
  `NRMC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(captured_byte_o) && $stable(buffer_position_o) && $stable(result_status_o), "result payload changed while stalled")

  // a timeout carries no character and position zero
  `NRMC_ASSERT(a_timeout_zero, clk_i, rst_ni, out_valid_o && result_status_o == nrmc_pkg::StTimeout |-> captured_byte_o == 8'd0 && buffer_position_o == 4'd0, "timeout beat with non-zero payload")

  // positions stay inside the field buffer and status codes are defined ones
  `NRMC_ASSERT(a_pos_range, clk_i, rst_ni, out_valid_o |-> buffer_position_o <= nrmc_pkg::MaxPos && (result_status_o == nrmc_pkg::StByte || result_status_o == nrmc_pkg::StDone || result_status_o == nrmc_pkg::StTimeout), "result position or status out of range")

endmodule

bind nmea_rmc_field_extractor_core nrmc_chk u_nrmc_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .captured_byte_o   (captured_byte_o),
  .buffer_position_o (buffer_position_o),
  .result_status_o   (result_status_o)
);
